@@ rtl/core/mtc_pkg.sv @@
// shared types and constants of the morse text codec
`timescale 1ns / 1ps

package mtc_pkg;

  // table geometry
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_SYMBOLS   = 8;
  localparam int PATTERN_BITS  = 8;
  localparam int SYMBOL_CAP    = (MAX_SYMBOLS < PATTERN_BITS) ? MAX_SYMBOLS : PATTERN_BITS;
  localparam int IDX_W         = 5;
  localparam int LEN_W         = 4;
  localparam int STEP_W        = 5;

  // characters
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_Z     = 8'd90;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_DASH  = 8'd45;

  localparam logic [STEP_W-1:0] WORD_SPACES   = 5'd4;
  localparam logic [STEP_W-1:0] LETTER_SPACES = 5'd3;

  // command codes
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENCODE,
    ST_SEARCH,
    ST_WORD
  } state_t;

  // lookup beat that walks down the cell chain
  typedef struct packed {
    logic                    valid;
    logic [LEN_W-1:0]        len;
    logic [PATTERN_BITS-1:0] pat;
    logic                    found;
    logic [IDX_W-1:0]        pos;
    logic [IDX_W-1:0]        idx;
  } search_beat_t;

  // keep only the pattern bits below the symbol count
  function automatic logic [PATTERN_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [PATTERN_BITS:0] one_hot;
    one_hot = (PATTERN_BITS+1)'(1) << len;
    if (len >= LEN_W'(PATTERN_BITS)) begin
      return {PATTERN_BITS{1'b1}};
    end
    return PATTERN_BITS'(one_hot - (PATTERN_BITS+1)'(1));
  endfunction

endpackage

@@ rtl/core/mtc_cell.sv @@
// one letter cell: holds a table entry and compares the passing lookup beat
`timescale 1ns / 1ps

module mtc_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   wr_en,
  input  logic [mtc_pkg::LEN_W-1:0]              wr_len,
  input  logic [mtc_pkg::PATTERN_BITS-1:0]       wr_pat,
  input  mtc_pkg::search_beat_t                  beat_i,
  output mtc_pkg::search_beat_t                  beat_o,
  output logic [mtc_pkg::LEN_W-1:0]              entry_len_o,
  output logic [mtc_pkg::PATTERN_BITS-1:0]       entry_pat_o
);

  logic [mtc_pkg::LEN_W-1:0]        len_r;
  logic [mtc_pkg::PATTERN_BITS-1:0] pat_r;
  mtc_pkg::search_beat_t            beat_r;
  mtc_pkg::search_beat_t            beat_nxt;
  logic                             hit;

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pat_r <= '0;
    end else if (wr_en) begin
      len_r <= wr_len;
      pat_r <= wr_pat;
    end
  end

  // first matching cell claims the beat
  always_comb begin
    hit      = beat_i.valid && !beat_i.found && (beat_i.len == len_r) &&
               (beat_i.pat == pat_r);
    beat_nxt = beat_i;
    beat_nxt.pos = beat_i.pos + mtc_pkg::IDX_W'(1);
    if (hit) begin
      beat_nxt.found = 1'b1;
      beat_nxt.idx   = beat_i.pos;
    end
  end

  // hand the beat to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_o      = beat_r;
  assign entry_len_o = len_r;
  assign entry_pat_o = pat_r;

endmodule

@@ rtl/core/morse_text_codec.sv @@
// morse text codec top level: command sequencer, decoder state and letter cell chain
`timescale 1ns / 1ps

// Takes one command when start is high and busy is low. A load writes one letter entry
// and leaves busy low. An encode emits its characters one per cycle, each registered
// from the encode state: 4 for a space, 2*length+2 for a letter (3 for an empty entry),
// and busy is high while they are produced. A decode character without a letter boundary
// and an end with no open letter leave busy low; a word space with no open letter appears
// on the cycle after acceptance. A letter boundary or an end with an open letter walks a
// lookup beat through the row of 26 letter cells, one cell per cycle; a matched letter is
// registered off the last cell, and an optional word space follows in the next cycle.
// Every result is shown for exactly one cycle with out_valid high; the receiver cannot
// stall, and out_last_of_run marks the final result of a command.
module morse_text_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_entry_index,
  input  logic [3:0] in_code_length,
  input  logic [7:0] in_code_pattern,
  input  logic [7:0] in_char,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       out_last_of_run
);

  localparam int N = mtc_pkg::ALPHABET_SIZE;

  mtc_pkg::state_t                      state_r, state_nxt;
  mtc_pkg::search_beat_t                chain [N+1];
  mtc_pkg::search_beat_t                launch_r, launch_nxt;
  logic [N:0]                           chain_valid;
  logic [mtc_pkg::LEN_W-1:0]            entry_len [N];
  logic [mtc_pkg::PATTERN_BITS-1:0]     entry_pat [N];
  logic [N-1:0]                         wr_en;
  logic [mtc_pkg::LEN_W-1:0]            wr_len;
  logic [mtc_pkg::PATTERN_BITS-1:0]     wr_pat;

  // decoder state
  logic [mtc_pkg::LEN_W-1:0]            gath_len_r, gath_len_nxt;
  logic [mtc_pkg::PATTERN_BITS-1:0]     gath_pat_r, gath_pat_nxt;
  logic [2:0]                           space_run_r, space_run_nxt;
  logic                                 letter_open_r, letter_open_nxt;
  logic                                 word_pend_r, word_pend_nxt;

  // encoder sequencer
  logic [mtc_pkg::STEP_W-1:0]           step_r, step_nxt;
  logic [mtc_pkg::STEP_W-1:0]           total_r, total_nxt;
  logic [mtc_pkg::LEN_W-1:0]            enc_len_r, enc_len_nxt;
  logic [mtc_pkg::PATTERN_BITS-1:0]     enc_pat_r, enc_pat_nxt;

  // result register
  logic                                 out_valid_r, out_valid_nxt;
  logic [7:0]                           out_char_r, out_char_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic                                 accept;
  logic [mtc_pkg::IDX_W-1:0]            letter_idx;
  logic [mtc_pkg::LEN_W-1:0]            base_len;
  logic [mtc_pkg::PATTERN_BITS-1:0]     base_pat;
  logic                                 flushing;
  logic                                 is_dash;
  logic                                 is_sym;

  assign accept = start && !busy;
  assign busy   = (state_r != mtc_pkg::ST_IDLE);

  // table write data: saturate the count and clear unused pattern bits
  always_comb begin
    wr_len = (in_code_length > mtc_pkg::LEN_W'(mtc_pkg::SYMBOL_CAP)) ?
             mtc_pkg::LEN_W'(mtc_pkg::SYMBOL_CAP) : in_code_length;
    wr_pat = in_code_pattern & mtc_pkg::len_mask(wr_len);
    wr_en  = '0;
    if (accept && (in_cmd == mtc_pkg::CMD_LOAD) &&
        (in_entry_index < mtc_pkg::IDX_W'(N))) begin
      wr_en[in_entry_index] = 1'b1;
    end
  end

  // row of letter cells
  assign chain[0]       = launch_r;
  assign chain_valid[0] = launch_r.valid;

  for (genvar k = 0; k < N; k++) begin : g_cell
    mtc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .wr_en       (wr_en[k]),
      .wr_len      (wr_len),
      .wr_pat      (wr_pat),
      .beat_i      (chain[k]),
      .beat_o      (chain[k+1]),
      .entry_len_o (entry_len[k]),
      .entry_pat_o (entry_pat[k])
    );
    assign chain_valid[k+1] = chain[k+1].valid;
  end

  assign letter_idx = mtc_pkg::IDX_W'(in_char - mtc_pkg::CH_A);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mtc_pkg::ST_IDLE;
      launch_r      <= '0;
      gath_len_r    <= '0;
      gath_pat_r    <= '0;
      space_run_r   <= '0;
      letter_open_r <= 1'b0;
      word_pend_r   <= 1'b0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      launch_r      <= launch_nxt;
      gath_len_r    <= gath_len_nxt;
      gath_pat_r    <= gath_pat_nxt;
      space_run_r   <= space_run_nxt;
      letter_open_r <= letter_open_nxt;
      word_pend_r   <= word_pend_nxt;
      step_r        <= step_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    enc_len_r  <= enc_len_nxt;
    enc_pat_r  <= enc_pat_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // next state and result beats
  always_comb begin
    state_nxt       = state_r;
    launch_nxt      = '0;
    gath_len_nxt    = gath_len_r;
    gath_pat_nxt    = gath_pat_r;
    space_run_nxt   = space_run_r;
    letter_open_nxt = letter_open_r;
    word_pend_nxt   = word_pend_r;
    step_nxt        = step_r;
    total_nxt       = total_r;
    enc_len_nxt     = enc_len_r;
    enc_pat_nxt     = enc_pat_r;
    out_valid_nxt   = 1'b0;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    flushing        = (space_run_r >= 3'd2);
    is_dash         = (in_char == mtc_pkg::CH_DASH);
    base_len        = flushing ? '0 : gath_len_r;
    base_pat        = flushing ? '0 : gath_pat_r;
    is_sym          = 1'b0;

    case (state_r)
      mtc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            mtc_pkg::CMD_ENCODE: begin
              step_nxt = '0;
              if (in_char == mtc_pkg::CH_SPACE) begin
                total_nxt   = mtc_pkg::WORD_SPACES;
                enc_len_nxt = '0;
                enc_pat_nxt = '0;
                state_nxt   = mtc_pkg::ST_ENCODE;
              end else if (in_char inside {[mtc_pkg::CH_A:mtc_pkg::CH_Z]}) begin
                enc_len_nxt = entry_len[letter_idx];
                enc_pat_nxt = entry_pat[letter_idx];
                total_nxt   = (entry_len[letter_idx] == '0) ? mtc_pkg::LETTER_SPACES :
                              ({1'b0, entry_len[letter_idx]} << 1) + mtc_pkg::STEP_W'(2);
                state_nxt   = mtc_pkg::ST_ENCODE;
              end
            end
            mtc_pkg::CMD_DECODE: begin
              if (in_char == mtc_pkg::CH_SPACE) begin
                if (space_run_r != 3'd7) begin
                  space_run_nxt = space_run_r + 3'd1;
                end
              end else if (in_char == mtc_pkg::CH_DOT || is_dash) begin
                // letter boundary before this symbol
                if (flushing) begin
                  word_pend_nxt = (space_run_r >= 3'd5);
                  if (letter_open_r) begin
                    launch_nxt.valid = 1'b1;
                    launch_nxt.len   = gath_len_r;
                    launch_nxt.pat   = gath_pat_r;
                    state_nxt        = mtc_pkg::ST_SEARCH;
                  end else if (space_run_r >= 3'd5) begin
                    out_valid_nxt = 1'b1;
                    out_char_nxt  = mtc_pkg::CH_SPACE;
                    out_last_nxt  = 1'b1;
                  end
                end
                // gather the new symbol
                space_run_nxt   = '0;
                letter_open_nxt = 1'b1;
                if (base_len < mtc_pkg::LEN_W'(mtc_pkg::SYMBOL_CAP)) begin
                  gath_pat_nxt = base_pat |
                                 (mtc_pkg::PATTERN_BITS'(is_dash) << base_len);
                  gath_len_nxt = base_len + mtc_pkg::LEN_W'(1);
                end else begin
                  gath_pat_nxt = base_pat;
                  gath_len_nxt = mtc_pkg::LEN_W'(mtc_pkg::SYMBOL_CAP + 1);
                end
              end
            end
            mtc_pkg::CMD_END: begin
              word_pend_nxt = 1'b0;
              if (letter_open_r) begin
                launch_nxt.valid = 1'b1;
                launch_nxt.len   = gath_len_r;
                launch_nxt.pat   = gath_pat_r;
                state_nxt        = mtc_pkg::ST_SEARCH;
              end
              gath_len_nxt    = '0;
              gath_pat_nxt    = '0;
              space_run_nxt   = '0;
              letter_open_nxt = 1'b0;
            end
            default: begin
              // table load is handled by the cell write enables
            end
          endcase
        end
      end
      mtc_pkg::ST_ENCODE: begin
        // symbols on even steps below 2*length-1, spaces elsewhere
        is_sym        = ((step_r + mtc_pkg::STEP_W'(1)) < ({1'b0, enc_len_r} << 1)) &&
                        !step_r[0];
        out_valid_nxt = 1'b1;
        out_char_nxt  = is_sym ? (enc_pat_r[step_r[3:1]] ? mtc_pkg::CH_DASH : mtc_pkg::CH_DOT)
                               : mtc_pkg::CH_SPACE;
        out_last_nxt  = (step_r == total_r - mtc_pkg::STEP_W'(1));
        step_nxt      = step_r + mtc_pkg::STEP_W'(1);
        if (out_last_nxt) begin
          state_nxt = mtc_pkg::ST_IDLE;
        end
      end
      mtc_pkg::ST_SEARCH: begin
        if (chain[N].valid) begin
          if (chain[N].found) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = mtc_pkg::CH_A + {3'b000, chain[N].idx};
            out_last_nxt  = !word_pend_r;
          end
          state_nxt = word_pend_r ? mtc_pkg::ST_WORD : mtc_pkg::ST_IDLE;
        end
      end
      mtc_pkg::ST_WORD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = mtc_pkg::CH_SPACE;
        out_last_nxt  = 1'b1;
        word_pend_nxt = 1'b0;
        state_nxt     = mtc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mtc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  // at most one lookup beat in the cell row
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_valid) <= 1)
    else $error("more than one lookup beat in flight");

  // a lookup beat only travels while the sequencer waits for it
  a_beat_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (|chain_valid) |-> (state_r == mtc_pkg::ST_SEARCH))
    else $error("lookup beat outside search state");

  // the beat leaving the last cell ends the search
  a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtc_pkg::ST_SEARCH && chain[N].valid) |=> (state_r != mtc_pkg::ST_SEARCH))
    else $error("search did not end on returning beat");

  // encode step stays inside its run
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtc_pkg::ST_ENCODE) |-> (step_r < total_r))
    else $error("encode step past run length");
`endif

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the morse text codec: directed and random command beats
`timescale 1ns / 1ps

module tb_top;
  import mtc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       start           = 1'b0;
  logic       busy;
  logic [1:0] in_cmd          = CMD_END;
  logic [4:0] in_entry_index  = '0;
  logic [3:0] in_code_length  = '0;
  logic [7:0] in_code_pattern = '0;
  logic [7:0] in_char         = '0;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last_of_run;

  // predicted codec state
  logic [3:0] tbl_len [ALPHABET_SIZE];
  logic [7:0] tbl_pat [ALPHABET_SIZE];
  logic [3:0] sym_count;
  logic [7:0] sym_bits;
  logic [2:0] gap_spaces;
  logic       letter_open;

  char_beat_t expected_chars [$];
  int         commands_issued = 0;
  int         mismatch_count  = 0;
  int         no_gap_left     = 0;
  int         idle_cycles     = 0;

  morse_text_codec u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_code_length  (in_code_length),
    .in_code_pattern (in_code_pattern),
    .in_char         (in_char),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  // close the gathered letter, returns the lowest matching table index or -1
  function automatic int close_letter();
    int hit;
    hit = -1;
    if (letter_open) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        if (tbl_len[k] == sym_count && tbl_pat[k] == sym_bits) begin
          hit = k;
          break;
        end
      end
    end
    letter_open = 1'b0;
    sym_count   = '0;
    sym_bits    = '0;
    return hit;
  endfunction

  // work out the characters one accepted command beat produces
  task automatic predict_codec_output(input cmd_t cmd, input logic [4:0] idx,
                                      input logic [3:0] len, input logic [7:0] pat,
                                      input logic [7:0] ch);
    logic [7:0] emitted [$];
    logic [3:0] keep_len;
    int         e;
    int         hit;
    case (cmd)
      CMD_LOAD: begin
        if (idx < ALPHABET_SIZE) begin
          keep_len = (len > SYMBOL_CAP) ? LEN_W'(SYMBOL_CAP) : len;
          tbl_len[idx] = keep_len;
          tbl_pat[idx] = (keep_len >= PATTERN_BITS) ? pat :
                         pat & 8'((9'd1 << keep_len) - 9'd1);
        end
      end
      CMD_ENCODE: begin
        if (ch == CH_SPACE) begin
          repeat (WORD_SPACES) emitted.push_back(CH_SPACE);
        end else if (ch >= CH_A && ch <= CH_Z) begin
          e = ch - CH_A;
          for (int s = 0; s < tbl_len[e]; s++) begin
            if (s > 0) emitted.push_back(CH_SPACE);
            emitted.push_back(tbl_pat[e][s] ? CH_DASH : CH_DOT);
          end
          repeat (LETTER_SPACES) emitted.push_back(CH_SPACE);
        end
      end
      CMD_DECODE: begin
        if (ch == CH_SPACE) begin
          if (gap_spaces < 3'd7) gap_spaces++;
        end else if (ch == CH_DOT || ch == CH_DASH) begin
          // a long enough gap ends the letter, a very long one also ends the word
          if (gap_spaces >= 2) begin
            hit = close_letter();
            if (hit >= 0) emitted.push_back(8'(CH_A + hit));
            if (gap_spaces >= 5) emitted.push_back(CH_SPACE);
          end
          gap_spaces  = '0;
          letter_open = 1'b1;
          if (sym_count < SYMBOL_CAP) begin
            if (ch == CH_DASH) sym_bits[sym_count] = 1'b1;
            sym_count++;
          end else begin
            sym_count = LEN_W'(SYMBOL_CAP + 1);
          end
        end
      end
      CMD_END: begin
        hit = close_letter();
        if (hit >= 0) emitted.push_back(8'(CH_A + hit));
        gap_spaces = '0;
      end
    endcase
    foreach (emitted[j]) begin
      expected_chars.push_back('{ch: emitted[j], last: (j == emitted.size() - 1)});
    end
  endtask

  // idle length after a beat: mostly short, some long, with bursts of none
  function automatic int pick_gap();
    int roll;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      no_gap_left = $urandom_range(8, 30);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one command beat, wait until it is taken, then idle for a random gap, possibly none
  task automatic issue_command(input cmd_t cmd, input logic [4:0] idx,
                               input logic [3:0] len, input logic [7:0] pat,
                               input logic [7:0] ch);
    int gap;
    in_cmd          <= cmd;
    in_entry_index  <= idx;
    in_code_length  <= len;
    in_code_pattern <= pat;
    in_char         <= ch;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_codec_output(cmd, idx, len, pat, ch);
    commands_issued++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [3:0] len,
                           input logic [7:0] pat);
    issue_command(CMD_LOAD, idx, len, pat, 8'($urandom));
  endtask

  task automatic send_encode(input logic [7:0] ch);
    issue_command(CMD_ENCODE, 5'($urandom), 4'($urandom), 8'($urandom), ch);
  endtask

  task automatic send_decode(input logic [7:0] ch);
    issue_command(CMD_DECODE, 5'($urandom), 4'($urandom), 8'($urandom), ch);
  endtask

  task automatic send_decode_spaces(input int count);
    repeat (count) send_decode(CH_SPACE);
  endtask

  task automatic send_end();
    issue_command(CMD_END, 5'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // any byte the decoder ignores
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c inside {CH_SPACE, CH_DOT, CH_DASH});
    return c;
  endfunction

  // symbols of one letter, mostly one space apart, sometimes none
  task automatic send_symbols(input int count, input logic [15:0] bits);
    for (int s = 0; s < count; s++) begin
      if (s > 0 && $urandom_range(0, 99) < 85) send_decode(CH_SPACE);
      if ($urandom_range(0, 99) < 3) send_decode(noise_char());
      send_decode(bits[s] ? CH_DASH : CH_DOT);
    end
  endtask

  // table edge cases, every command, gap rules
  task automatic test_directed_cases();
    send_end();                            // end with nothing open
    send_load(5'd0, 4'd2, 8'b0000_0010);   // A = .-
    send_load(5'd2, 4'd2, 8'hFE);          // same code after masking, A must win
    send_load(5'd31, 4'd3, 8'h00);         // index past the alphabet
    send_load(5'd25, 4'd15, 8'hFF);        // over-long entry, saturates
    send_load(5'd1, 4'd0, 8'hFF);          // empty entry
    send_encode(CH_A);
    send_encode(CH_Z);                     // longest output of one beat
    send_encode(8'd66);                    // empty entry gives letter spaces only
    send_encode(CH_SPACE);
    send_encode(8'h00);
    send_encode(8'hFF);
    send_decode_spaces(5);                 // word space with no letter open
    send_decode(CH_DOT);
    send_decode(CH_DASH);
    send_decode(8'd42);                    // ignored character
    send_decode_spaces(2);
    send_decode(CH_DOT);                   // letter gap flushes .-
    send_end();                            // lone dot matches nothing
  endtask

  // fill the whole table with random codes, a few over-long
  task automatic test_table_load();
    int roll;
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) send_load(5'(k), 4'($urandom_range(9, 15)), 8'($urandom));
      else if (roll < 25) send_load(5'(k), 4'($urandom_range(7, 8)), 8'($urandom));
      else send_load(5'(k), 4'($urandom_range(1, 6)), 8'($urandom));
    end
  endtask

  task automatic test_encode_text(input int target);
    int roll;
    while (commands_issued < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) send_encode(8'($urandom_range(CH_A, CH_Z)));
      else if (roll < 85) send_encode(CH_SPACE);
      else send_encode(8'($urandom));
    end
  endtask

  // messages of words built from table codes, with some broken gaps and bad letters
  task automatic test_decode_stream(input int target);
    int          words;
    int          letters;
    int          pick;
    int          sym_total;
    int          gap;
    int          idx;
    logic [15:0] code;
    while (commands_issued < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_load(5'($urandom_range(0, ALPHABET_SIZE - 1)), 4'($urandom_range(1, 8)),
                  8'($urandom));
      end
      words = $urandom_range(1, 4);
      for (int w = 0; w < words; w++) begin
        letters = $urandom_range(1, 5);
        for (int l = 0; l < letters; l++) begin
          pick = $urandom_range(0, 99);
          if (pick < 80) begin
            idx       = $urandom_range(0, ALPHABET_SIZE - 1);
            sym_total = tbl_len[idx];
            code      = 16'(tbl_pat[idx]);
          end else if (pick < 90) begin
            sym_total = $urandom_range(1, SYMBOL_CAP);
            code      = 16'($urandom);
          end else begin
            sym_total = $urandom_range(SYMBOL_CAP + 1, SYMBOL_CAP + 4);
            code      = 16'($urandom);
          end
          if (sym_total == 0) sym_total = 1;
          send_symbols(sym_total, code);
          // letter gap, word gap, trailing spaces or a broken gap
          if (w == words - 1 && l == letters - 1) gap = $urandom_range(0, 6);
          else if ($urandom_range(0, 99) < 10) gap = $urandom_range(0, 9);
          else if (l == letters - 1) gap = $urandom_range(5, 9);
          else gap = $urandom_range(2, 4);
          send_decode_spaces(gap);
        end
      end
      send_end();
    end
  endtask

  // fully random beats over every field
  task automatic test_random_mix(input int target);
    while (commands_issued < target) begin
      issue_command(cmd_t'($urandom_range(0, 3)), 5'($urandom), 4'($urandom),
                    8'($urandom), 8'($urandom));
    end
  endtask

  task automatic flag_mismatch(input string want_text);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: expected %s, got char %h last %b",
               $time, want_text, out_char, out_last_of_run);
    end
  endtask

  // compare every result beat with the oldest expected character
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (expected_chars.size() == 0) begin
        flag_mismatch("no character");
      end else begin
        want = expected_chars.pop_front();
        if (out_valid !== 1'b1 || out_char !== want.ch || out_last_of_run !== want.last) begin
          flag_mismatch($sformatf("char %h last %b", want.ch, want.last));
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      tbl_len[k] = '0;
      tbl_pat[k] = '0;
    end
    sym_count   = '0;
    sym_bits    = '0;
    gap_spaces  = '0;
    letter_open = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_table_load();
    test_encode_text(commands_issued + 90);
    test_decode_stream(380);
    test_random_mix(commands_issued + 40);
    start <= 1'b0;

    // drain, then allow for a late lookup
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
